// File: hdl/dtt_pkg.sv
// shared types and constants for the deadline timer table
// no dependencies; imported by every module under hdl
package dtt_pkg;

    localparam int NUM_ALARMS = 16;
    localparam int ID_W       = 4;
    localparam int TIME_W     = 48;
    localparam int REQ_W      = 2;
    localparam int S_DATA_W   = 104;
    localparam int M_DATA_W   = 56;

    typedef enum logic [REQ_W-1:0] {
        REQ_SET    = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_TICK   = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_REMOVE,
        OP_INSERT,
        OP_POP
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_FIRE
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] deadline;
    } cell_data_t;

    typedef struct packed {
        cell_op_t          op;
        logic [ID_W-1:0]   key_id;
        logic [TIME_W-1:0] key_deadline;
    } cell_ctl_t;

endpackage

// File: hdl/dtt_cell.sv
// one slot of the sorted alarm chain: holds one alarm and its deadline
// depends on dtt_pkg; instantiated by dtt_chain
module dtt_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  dtt_pkg::cell_ctl_t ctl,
    input  dtt_pkg::cell_data_t left,
    input  dtt_pkg::cell_data_t right,
    input  logic               rm_in,
    input  logic               place_in,
    output dtt_pkg::cell_data_t data,
    output logic               rm_out,
    output logic               place_out
);
    import dtt_pkg::*;

    logic              valid_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] deadline_reg;
    cell_data_t        data_next;
    cell_data_t        fresh;

    assign data.valid    = valid_reg;
    assign data.id       = id_reg;
    assign data.deadline = deadline_reg;

    assign fresh.valid    = 1'b1;
    assign fresh.id       = ctl.key_id;
    assign fresh.deadline = ctl.key_deadline;

    // removal ripples toward the tail, insertion point is the first later slot
    assign rm_out    = rm_in | (valid_reg && (id_reg == ctl.key_id));
    assign place_out = !valid_reg || (deadline_reg > ctl.key_deadline);

    always_comb begin
        data_next = data;
        case (ctl.op)
            OP_REMOVE: begin
                if (rm_out) begin
                    data_next = right;
                end
            end
            OP_INSERT: begin
                if (place_out) begin
                    data_next = place_in ? left : fresh;
                end
            end
            OP_POP: begin
                data_next = right;
            end
            default: begin
                data_next = data;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= data_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg       <= data_next.id;
        deadline_reg <= data_next.deadline;
    end

endmodule

// File: hdl/dtt_chain.sv
// row of alarm cells kept sorted by deadline, then by arrival
// depends on dtt_pkg and dtt_cell; instantiated by the top level
module dtt_chain (
    input  logic               aclk,
    input  logic               aresetn,
    input  dtt_pkg::cell_ctl_t ctl,
    output dtt_pkg::cell_data_t cells [dtt_pkg::NUM_ALARMS+1]
);
    import dtt_pkg::*;

    logic rm   [NUM_ALARMS+1];
    logic place[NUM_ALARMS+1];

    assign rm[0]    = 1'b0;
    assign place[0] = 1'b0;
    assign cells[NUM_ALARMS] = '0;

    for (genvar i = 0; i < NUM_ALARMS; i++) begin : g_cell
        cell_data_t left_data;
        if (i == 0) begin : g_head
            assign left_data = '0;
        end else begin : g_body
            assign left_data = cells[i-1];
        end

        dtt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .left      (left_data),
            .right     (cells[i+1]),
            .rm_in     (rm[i]),
            .place_in  (place[i]),
            .data      (cells[i]),
            .rm_out    (rm[i+1]),
            .place_out (place[i+1])
        );
    end

endmodule

// File: hdl/deadline_timer_table_top.sv
// deadline timer table: sorted chain of alarm cells with set, cancel and tick
// depends on dtt_pkg and dtt_chain
//
//  port group   dir  payload
//  s_*          in   tuser req_type, tdata alarm_id / deadline_ms / now_ms
//  m_*          out  tdata fired_id / fired_deadline, tlast last_fired
//  cfg_*        in   engine_stopped
//
// set runs a remove pass, then an insert pass; cancel runs a remove pass only
// tick fires every due alarm in turn, popped from the chain head
// reset empties the chain at once and clears engine_stopped
// a stalled m_tready holds the chain head; a new item is taken only in idle
module deadline_timer_table_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // alarm_id[3:0], deadline_ms[51:4], now_ms[99:52], zero fill
    input  logic [dtt_pkg::S_DATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [dtt_pkg::REQ_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // fired_id[3:0], fired_deadline[51:4], zero fill
    output logic [dtt_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);
    import dtt_pkg::*;

    state_t            state_reg, state_next;
    logic              stopped_reg;
    logic [ID_W-1:0]   key_id_reg;
    logic [TIME_W-1:0] key_deadline_reg;
    logic [TIME_W-1:0] now_reg;
    logic              m_valid_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [TIME_W-1:0] out_deadline_reg;
    logic              out_last_reg;

    logic [ID_W-1:0]   in_id;
    logic [TIME_W-1:0] in_deadline;
    logic [TIME_W-1:0] in_now;
    logic              accept;
    logic              in_range;
    logic              head_hit;
    logic              next_hit;
    logic              out_free;
    logic              pop;
    logic              load_set;
    logic              load_tick;
    cell_ctl_t         ctl;
    cell_data_t        cells [NUM_ALARMS+1];
    logic [NUM_ALARMS-1:0] valid_vec;

    assign in_id       = s_tdata[ID_W-1:0];
    assign in_deadline = s_tdata[ID_W+TIME_W-1:ID_W];
    assign in_now      = s_tdata[ID_W+2*TIME_W-1:ID_W+TIME_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_range = (32'(in_id) < NUM_ALARMS);

    assign head_hit = cells[0].valid && (cells[0].deadline <= now_reg);
    assign next_hit = cells[1].valid && (cells[1].deadline <= now_reg);
    assign out_free = !m_valid_reg || m_tready;

    dtt_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .cells   (cells)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser == REQ_SET) && !stopped_reg && in_range) begin
                    state_next = ST_INSERT;
                end else if (accept && (s_tuser == REQ_TICK)) begin
                    state_next = ST_FIRE;
                end
            end
            ST_INSERT: begin
                state_next = ST_IDLE;
            end
            ST_FIRE: begin
                if (!head_hit || (out_free && !next_hit)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl.op           = OP_HOLD;
        ctl.key_id       = key_id_reg;
        ctl.key_deadline = key_deadline_reg;
        pop              = 1'b0;
        load_set         = 1'b0;
        load_tick        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                ctl.key_id = in_id;
                if (accept) begin
                    case (s_tuser)
                        REQ_SET: begin
                            if (!stopped_reg && in_range) begin
                                ctl.op   = OP_REMOVE;
                                load_set = 1'b1;
                            end
                        end
                        REQ_CANCEL: begin
                            if (in_range) begin
                                ctl.op = OP_REMOVE;
                            end
                        end
                        REQ_TICK: begin
                            load_tick = 1'b1;
                        end
                        default: begin
                            ctl.op = OP_HOLD;
                        end
                    endcase
                end
            end
            ST_INSERT: begin
                ctl.op = OP_INSERT;
            end
            ST_FIRE: begin
                if (head_hit && out_free) begin
                    ctl.op = OP_POP;
                    pop    = 1'b1;
                end
            end
            default: begin
                ctl.op = OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            stopped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                stopped_reg <= cfg_wdata;
            end
            if (pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_set) begin
            key_id_reg       <= in_id;
            key_deadline_reg <= in_deadline;
        end
        if (load_tick) begin
            now_reg <= in_now;
        end
        if (pop) begin
            out_id_reg       <= cells[0].id;
            out_deadline_reg <= cells[0].deadline;
            out_last_reg     <= !next_hit;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-ID_W-TIME_W){1'b0}}, out_deadline_reg, out_id_reg};
    assign m_tlast  = out_last_reg;

    for (genvar i = 0; i < NUM_ALARMS; i++) begin : g_valid
        assign valid_vec[i] = cells[i].valid;
    end

    // armed alarms always sit packed at the chain head
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_vec & (valid_vec + NUM_ALARMS'(1))) == '0)
        else $error("chain holes between armed cells");

    // head stays in deadline order
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cells[0].valid && cells[1].valid) |-> (cells[0].deadline <= cells[1].deadline))
        else $error("chain head out of deadline order");

    // a fired item never overwrites one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (!m_tvalid || m_tready))
        else $error("fired item dropped on stalled output");

endmodule
